// ----- rtl/core/mpct_pkg.sv -----
// Shared types and constants for the mouse packet cursor tracker.
package mpct_pkg;

  localparam int unsigned COORD_W  = 12;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned SUM_W    = COORD_W + 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = CFG_IDX_W'(1);

  localparam logic [COORD_W-1:0] X_LIMIT_RST = COORD_W'(319);
  localparam logic [COORD_W-1:0] Y_LIMIT_RST = COORD_W'(199);
  localparam logic [COORD_W-1:0] POS_X_RST   = COORD_W'(160);
  localparam logic [COORD_W-1:0] POS_Y_RST   = COORD_W'(100);

  // header byte bits
  localparam int unsigned HDR_SYNC_BIT = 3;
  localparam int unsigned HDR_XSGN_BIT = 4;
  localparam int unsigned HDR_YSGN_BIT = 5;

  // decoded packet, valid only when done is set
  typedef struct packed {
    logic              done;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic [2:0]        buttons;
  } pkt_t;

endpackage

// ----- rtl/core/mouse_packet_cursor_tracker.sv -----
// Top level: input beat register, packet framer, cursor update and result register.
//
// Usage
//   Input channel (in_valid / in_ready / in_mouse_byte) takes one raw device
//   byte per beat. The second byte after a header (sync bit 3 set) closes a
//   packet and yields one result beat on out_valid / out_ready carrying the
//   clamped cursor position and the button bits. Header-slot bytes without the
//   sync bit are dropped and give no result.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
//   ready; index 0 sets the x limit, index 1 the y limit, others are ignored.
//   Write it only while no packet bytes are in flight.
// Timing
//   One byte per cycle while the result side does not stall. A byte is held
//   in the input register and the framer plus the add-and-clamp path load the
//   result register from it once the result slot is free.
// Stall
//   While a result waits for out_ready the input register holds its byte and
//   in_ready stays low; if it is empty, one more byte can be taken, then in_ready drops.
// Reset
//   Limits return to 319/199, cursor to (160,100), framer to the header slot,
//   both pipeline registers empty.
module mouse_packet_cursor_tracker
  import mpct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_mouse_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COORD_W-1:0]   out_cursor_x,
  output logic [COORD_W-1:0]   out_cursor_y,
  output logic [2:0]           out_button_bits,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  logic [COORD_W-1:0] x_limit_r, y_limit_r;
  logic               in_vld_r;
  logic [7:0]         in_byte_r;
  logic               out_vld_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [2:0]         out_btn_r;

  logic               advance, fire;
  pkt_t               pkt;
  logic [COORD_W-1:0] x_nxt, y_nxt;

  // the byte in the input register moves on whenever the result slot is free
  assign advance  = !out_vld_r || out_ready;
  assign fire     = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= X_LIMIT_RST;
      y_limit_r <= Y_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_LIMIT: x_limit_r <= cfg_data;
        REG_Y_LIMIT: y_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_mouse_byte;
    end
  end

  mpct_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .mouse_byte (in_byte_r),
    .pkt        (pkt)
  );

  mpct_cursor u_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .pkt     (pkt),
    .x_limit (x_limit_r),
    .y_limit (y_limit_r),
    .x_nxt   (x_nxt),
    .y_nxt   (y_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= fire && pkt.done;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pkt.done) begin
      out_x_r   <= x_nxt;
      out_y_r   <= y_nxt;
      out_btn_r <= pkt.buttons;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_cursor_x    = out_x_r;
  assign out_cursor_y    = out_y_r;
  assign out_button_bits = out_btn_r;

  // a held byte must not be lost or overwritten while the result slot is blocked
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> (in_vld_r && $stable(in_byte_r)))
    else $error("input beat lost during stall");

  // a closing byte always lands in the result register
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && pkt.done) |=> out_vld_r)
    else $error("completed packet gave no result");

  // reset empties both pipeline registers
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_vld_r && !in_vld_r))
    else $error("pipeline not empty after reset");

endmodule

// ----- rtl/core/mpct_framer.sv -----
// Byte framer: finds the header and assembles three-byte movement packets.
module mpct_framer
  import mpct_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] mouse_byte,
  output pkt_t       pkt
);

  localparam logic [1:0] POS_HDR = 2'd0;
  localparam logic [1:0] POS_X   = 2'd1;
  localparam logic [1:0] POS_Y   = 2'd2;

  logic [1:0] pos_r, pos_nxt;
  logic [7:0] hdr_r, hdr_nxt;
  logic [7:0] xb_r, xb_nxt;

  always_comb begin
    pos_nxt = pos_r;
    hdr_nxt = hdr_r;
    xb_nxt  = xb_r;
    case (pos_r)
      POS_X: begin
        xb_nxt  = mouse_byte;
        pos_nxt = POS_Y;
      end
      POS_Y: begin
        pos_nxt = POS_HDR;
      end
      default: begin
        // header slot (and the unused code): keep only bytes with sync set
        if (mouse_byte[HDR_SYNC_BIT]) begin
          hdr_nxt = mouse_byte;
          pos_nxt = POS_X;
        end else begin
          pos_nxt = POS_HDR;
        end
      end
    endcase
  end

  always_comb begin
    pkt.done    = (pos_r == POS_Y);
    pkt.dx      = {hdr_r[HDR_XSGN_BIT], xb_r};
    pkt.dy      = {hdr_r[HDR_YSGN_BIT], mouse_byte};
    pkt.buttons = hdr_r[2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HDR;
      hdr_r <= 8'h00;
      xb_r  <= 8'h00;
    end else if (fire) begin
      pos_r <= pos_nxt;
      hdr_r <= hdr_nxt;
      xb_r  <= xb_nxt;
    end
  end

endmodule

// ----- rtl/core/mpct_cursor.sv -----
// Cursor position registers with add and clamp.
module mpct_cursor
  import mpct_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  pkt_t               pkt,
  input  logic [COORD_W-1:0] x_limit,
  input  logic [COORD_W-1:0] y_limit,
  output logic [COORD_W-1:0] x_nxt,
  output logic [COORD_W-1:0] y_nxt
);

  logic [COORD_W-1:0] pos_x_r, pos_y_r;
  logic signed [SUM_W-1:0] sum_x, sum_y;

  function automatic logic [COORD_W-1:0] clamp(input logic signed [SUM_W-1:0] v,
                                               input logic [COORD_W-1:0] lim);
    logic [COORD_W-1:0] res;
    if (v[SUM_W-1]) begin
      res = '0;
    end else if (v[SUM_W-2:0] > {1'b0, lim}) begin
      res = lim;
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

  always_comb begin
    sum_x = $signed({2'b00, pos_x_r}) + SUM_W'(pkt.dx);
    sum_y = $signed({2'b00, pos_y_r}) - SUM_W'(pkt.dy);
    x_nxt = clamp(sum_x, x_limit);
    y_nxt = clamp(sum_y, y_limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= POS_X_RST;
      pos_y_r <= POS_Y_RST;
    end else if (fire && pkt.done) begin
      pos_x_r <= x_nxt;
      pos_y_r <= y_nxt;
    end
  end

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the mouse packet cursor tracker: framing, clamping, limit registers.
`timescale 1ns / 1ps

module testbench;
  import mpct_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned SETTLE_CYC  = 4;

  // one cursor result beat
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [2:0]         buttons;
  } cursor_beat_t;

  // where the framer is within a packet
  typedef enum logic [1:0] {
    SLOT_HEADER,
    SLOT_XMOVE,
    SLOT_YMOVE
  } slot_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_mouse_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COORD_W-1:0]   out_cursor_x;
  logic [COORD_W-1:0]   out_cursor_y;
  logic [2:0]           out_button_bits;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data = '0;

  // tracker mirror: framer, cursor and limits as the block should hold them
  slot_t              frame_slot;
  logic [7:0]         hdr_byte;
  logic [7:0]         xmove_byte;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic [COORD_W-1:0] lim_x;
  logic [COORD_W-1:0] lim_y;
  cursor_beat_t       pending_cursor[$];

  int mismatches    = 0;
  int cycle_count   = 0;
  int in_gap_pct    = 25;   // chance per byte of a sender gap burst
  int out_stall_pct = 25;   // chance per cycle of a receiver stall burst
  int stall_left    = 0;

  mouse_packet_cursor_tracker uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mouse_byte   (in_mouse_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cursor_x    (out_cursor_x),
    .out_cursor_y    (out_cursor_y),
    .out_button_bits (out_button_bits),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a leftover expectation or a hung handshake ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tracker mirror
  // ---------------------------------------------------------------------------

  function automatic void tracker_reset();
    frame_slot = SLOT_HEADER;
    hdr_byte   = '0;
    xmove_byte = '0;
    cur_x      = POS_X_RST;
    cur_y      = POS_Y_RST;
    lim_x      = X_LIMIT_RST;
    lim_y      = Y_LIMIT_RST;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_to(int v, logic [COORD_W-1:0] lim);
    if (v < 0) return '0;
    if (v > int'(lim)) return lim;
    return COORD_W'(v);
  endfunction

  // Advance the framer by one accepted byte; a closing byte queues the new cursor.
  function automatic void track_byte(logic [7:0] b);
    int           dx;
    int           dy;
    cursor_beat_t beat;
    case (frame_slot)
      SLOT_XMOVE: begin
        xmove_byte = b;
        frame_slot = SLOT_YMOVE;
      end
      SLOT_YMOVE: begin
        // 9-bit movement: header carries the sign, overflow bits play no part
        dx = int'(xmove_byte) - (hdr_byte[HDR_XSGN_BIT] ? 256 : 0);
        dy = int'(b) - (hdr_byte[HDR_YSGN_BIT] ? 256 : 0);
        cur_x = clamp_to(int'(cur_x) + dx, lim_x);
        cur_y = clamp_to(int'(cur_y) - dy, lim_y);   // y grows downward
        beat.x       = cur_x;
        beat.y       = cur_y;
        beat.buttons = hdr_byte[2:0];
        pending_cursor.push_back(beat);
        frame_slot = SLOT_HEADER;
      end
      default: begin
        // header slot: bytes without the sync bit are dropped
        if (b[HDR_SYNC_BIT]) begin
          hdr_byte   = b;
          frame_slot = SLOT_XMOVE;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, and the beat checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 15);   // rest of the burst, random length
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Values read here are the ones present before the edge, so the handshake
  // seen is the one the block sees.
  always @(posedge clk) begin
    cursor_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cursor.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected cursor beat: x=%0d y=%0d buttons=%0d",
                   out_cursor_x, out_cursor_y, out_button_bits);
      end else begin
        want = pending_cursor.pop_front();
        if (out_cursor_x !== want.x || out_cursor_y !== want.y ||
            out_button_bits !== want.buttons) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("cursor beat mismatch: expected x=%0d y=%0d buttons=%0d,",
                     want.x, want.y, want.buttons,
                     " got x=%0d y=%0d buttons=%0d",
                     out_cursor_x, out_cursor_y, out_button_bits);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // One byte beat, with an occasional gap burst ahead of it. Valid stays up
  // after acceptance so back-to-back beats need no re-raise.
  task automatic send_byte(input logic [7:0] b);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mouse_byte <= b;
    do @(posedge clk); while (!in_ready);
    track_byte(b);
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xb,
                             input logic [7:0] yb);
    send_byte(hdr);
    send_byte(xb);
    send_byte(yb);
  endtask

  // Let the block go quiet: every result back, plus room for a dropped byte
  // still sitting in the input register.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_cursor.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Caller lowers cfg_valid once the last write of a series is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_X_LIMIT)
      lim_x = data;
    else if (idx == REG_Y_LIMIT)
      lim_y = data;
  endtask

  task automatic set_limits(input logic [COORD_W-1:0] x_lim, input logic [COORD_W-1:0] y_lim);
    settle();
    write_reg(REG_X_LIMIT, x_lim);
    write_reg(REG_Y_LIMIT, y_lim);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed packets with random content, some stray bytes that
  // either get dropped or knock the framing out of step. A non-zero drift
  // pushes the cursor hard along one diagonal to reach the clamp bounds.
  task automatic run_random_phase(input int n_bytes, input int drift);
    int         sent;
    logic [7:0] hdr;
    logic [7:0] xb;
    logic [7:0] yb;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(0, 7) == 0) begin
        send_byte(8'($urandom));
      end else begin
        hdr = 8'($urandom);
        hdr[HDR_SYNC_BIT] = 1'b1;
        xb  = 8'($urandom);
        yb  = 8'($urandom);
        if (drift != 0 && $urandom_range(0, 3) != 0) begin
          hdr[HDR_XSGN_BIT] = (drift < 0);
          hdr[HDR_YSGN_BIT] = (drift > 0);
          xb = (drift > 0) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 127));
          yb = (drift > 0) ? 8'($urandom_range(0, 127)) : 8'($urandom_range(128, 255));
        end
        send_packet(hdr, xb, yb);
        sent += 3;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Sync-bit filtering, all-ones and all-zeros bytes, sign handling and
  // clamping at both ends under the reset limits.
  task automatic test_framing_and_extremes();
    send_byte(8'h00);                       // no sync bit: dropped
    send_byte(8'hF7);                       // every bit but sync: dropped
    send_packet(8'h08, 8'h00, 8'h00);       // no movement, no buttons
    send_packet(8'hFF, 8'hFF, 8'hFF);       // all buttons, both signs, overflow set
    send_packet(8'h18, 8'h00, 8'h7F);       // full left, full up: pinned at zero
    send_packet(8'h2D, 8'hFF, 8'h00);       // full right, full down: y at limit
    send_packet(8'hCA, 8'h80, 8'h80);       // overflow bits only; x past limit
    send_byte(8'h37);                       // stray byte between packets
    send_packet(8'h0F, 8'h01, 8'hFE);
  endtask

  // Zero limits, ignored register indexes, and a limit lowered below the
  // current cursor which only bites at the next packet.
  task automatic test_limit_registers();
    int idx;
    set_limits('0, '0);
    send_packet(8'h08, 8'h40, 8'h80);       // both coordinates pinned at zero

    // indexes past the register list must leave both limits alone
    settle();
    for (idx = int'(REG_Y_LIMIT) + 1; idx < 2 ** CFG_IDX_W; idx++)
      write_reg(CFG_IDX_W'(idx), COORD_W'($urandom));
    write_reg(CFG_IDX_W'(2 ** CFG_IDX_W - 1), '1);
    cfg_valid <= 1'b0;
    send_packet(8'h0C, 8'h7F, 8'h81);

    set_limits('1, '1);
    send_packet(8'h28, 8'hFF, 8'h01);       // well out into the field
    send_packet(8'h28, 8'hFF, 8'h01);
    set_limits(COORD_W'(10), COORD_W'(20)); // cursor now past both limits
    send_packet(8'h09, 8'h00, 8'h00);       // zero move: clamp applies now
    set_limits(COORD_W'(1), '1);
    send_packet(8'h2A, 8'h05, 8'h10);
  endtask

  task automatic test_random_traffic();
    // wide limits, drifting towards the far corner
    set_limits('1, '1);
    run_random_phase(105, 1);

    // limits of one with only light idling
    in_gap_pct    = 5;
    out_stall_pct = 5;
    set_limits(COORD_W'(1), COORD_W'(1));
    run_random_phase(60, 0);

    // random limits, drifting back towards the origin
    in_gap_pct    = 30;
    out_stall_pct = 30;
    set_limits(COORD_W'($urandom_range(1, 4095)), COORD_W'($urandom_range(1, 4095)));
    run_random_phase(90, -1);

    set_limits(X_LIMIT_RST, Y_LIMIT_RST);
    run_random_phase(90, 0);

    // closing stretch flat out on both sides
    in_gap_pct    = 0;
    out_stall_pct = 0;
    set_limits(COORD_W'($urandom_range(1, 4095)), COORD_W'($urandom_range(1, 4095)));
    run_random_phase(60, 0);
  endtask

  initial begin
    tracker_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_framing_and_extremes();
    test_limit_registers();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pending_cursor.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- mouse_packet_cursor_tracker.f -----
rtl/core/mpct_pkg.sv
rtl/core/mpct_framer.sv
rtl/core/mpct_cursor.sv
rtl/core/mouse_packet_cursor_tracker.sv
bench/testbench.sv
